// ===== sv/oti_pkg.sv =====
// Shared types, constants and helpers for the odometer/trip integrator.
package oti_pkg;

  // Request codes carried in req_type
  typedef enum logic [1:0] {
    REQ_ACCUM      = 2'd0,
    REQ_TRIP_RESET = 2'd1,
    REQ_INIT       = 2'd2,
    REQ_NONE       = 2'd3
  } req_t;

  // Register index (paddr[2])
  typedef enum logic {
    REG_ODO_STORED  = 1'b0,
    REG_TRIP_STORED = 1'b1
  } reg_idx_t;

  localparam int unsigned CHECKPOINT_TENTHS = 10;

  typedef logic [31:0] total_t;
  typedef logic [18:0] rem_t;   // speed*ms remainder, below 360000
  typedef logic [19:0] prod_t;  // clamped speed*ms, up to 1000000
  typedef logic [20:0] sum_t;   // remainder + product
  typedef logic [9:0]  narrow_t;
  typedef logic [3:0]  ckpt_t;

  localparam sum_t     DECI_KM_UNITS     = 21'd360000;
  localparam logic [15:0] SPEED_LIMIT_KPH   = 16'd1000;
  localparam logic [31:0] INTERVAL_LIMIT_MS = 32'd1000;
  localparam logic [4:0]  CKPT_LIMIT        = 5'(CHECKPOINT_TENTHS);

  typedef struct packed {
    total_t odometer_stored;
    total_t trip_stored;
  } cfg_regs_t;

  typedef struct packed {
    rem_t        rem;
    logic [1:0]  inc;
  } meter_res_t;

  // Saturating add of a 0..3 increment
  function automatic total_t sat_add(input total_t base, input logic [1:0] inc);
    logic [32:0] s;
    s = {1'b0, base} + {31'd0, inc};
    return s[32] ? '1 : s[31:0];
  endfunction

  // Checkpoint wrap: sum is at most CKPT_LIMIT-1+3, so three steps cover any limit
  function automatic logic [4:0] ckpt_wrap(input logic [4:0] sum);
    logic [4:0] v;
    v = sum;
    for (int i = 0; i < 3; i++) begin
      if (v >= CKPT_LIMIT) begin
        v = v - CKPT_LIMIT;
      end
    end
    return v;
  endfunction

endpackage

// ===== sv/oti_meter_step.sv =====
// One meter's remainder update: whole tenths out of remainder plus speed*ms.
module oti_meter_step (
  input  oti_pkg::rem_t       rem_i,
  input  oti_pkg::prod_t      prod_i,
  output oti_pkg::meter_res_t res_o
);

  oti_pkg::sum_t n;
  oti_pkg::sum_t sub;
  logic [1:0]    q;

  always_comb begin
    n = {2'b00, rem_i} + {1'b0, prod_i};
    // quotient is 0..3, so three compares against multiples of the unit
    if (n >= 21'(3 * oti_pkg::DECI_KM_UNITS)) begin
      q   = 2'd3;
      sub = 21'(3 * oti_pkg::DECI_KM_UNITS);
    end else if (n >= 21'(2 * oti_pkg::DECI_KM_UNITS)) begin
      q   = 2'd2;
      sub = 21'(2 * oti_pkg::DECI_KM_UNITS);
    end else if (n >= oti_pkg::DECI_KM_UNITS) begin
      q   = 2'd1;
      sub = oti_pkg::DECI_KM_UNITS;
    end else begin
      q   = 2'd0;
      sub = '0;
    end
    res_o.inc = q;
    res_o.rem = 19'(n - sub);
  end

endmodule

// ===== sv/oti_cfg_regs.sv =====
// APB-style register file holding the stored odometer and trip values.
module oti_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output oti_pkg::cfg_regs_t regs_o
);

  oti_pkg::cfg_regs_t regs_r;
  oti_pkg::cfg_regs_t regs_nxt;
  oti_pkg::reg_idx_t  idx;

  assign idx    = oti_pkg::reg_idx_t'(paddr[2]);
  assign pready = 1'b1;
  assign regs_o = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    if (psel && penable && pwrite && pready) begin
      case (idx)
        oti_pkg::REG_ODO_STORED:  regs_nxt.odometer_stored = pwdata;
        oti_pkg::REG_TRIP_STORED: regs_nxt.trip_stored     = pwdata;
        default: regs_nxt = regs_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      oti_pkg::REG_ODO_STORED:  prdata = regs_r.odometer_stored;
      oti_pkg::REG_TRIP_STORED: prdata = regs_r.trip_stored;
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '0;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

// ===== sv/odometer_trip_integrator.sv =====
// Top level: input register, odometer/trip update logic, result register.
// An accepted input beat goes through the input register, then the result register, to out_*.
// Throughput: one beat per cycle while out_stall is low; the update (10x10 multiply,
//   divide by 360000 in three compares, saturating add) sits between both registers.
// Reset (rst_n low, synchronous): totals, remainders, checkpoint count, moving
//   flag, stored registers and both valid flags clear; payload regs keep values.
module odometer_trip_integrator (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_speed_kph,
  input  logic [31:0] in_elapsed_ms,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_odometer_deci_km,
  output logic [31:0] out_trip_deci_km,
  output logic        out_save_request,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  oti_pkg::cfg_regs_t cfg;

  oti_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .regs_o  (cfg)
  );

  // ---------------------------------------------------------------
  // Handshake: the result register frees up when empty or taken, the
  // input register moves whenever the result register can load.
  // ---------------------------------------------------------------
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_ready;
  logic s1_fire;
  logic in_fire;

  assign out_ready = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && out_ready;
  assign in_stall  = s1_valid_r && !out_ready;
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Input register (payload, no reset)
  logic [1:0]  s1_req_r;
  logic [15:0] s1_speed_r;
  logic [31:0] s1_ms_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r   <= in_req_type;
      s1_speed_r <= in_speed_kph;
      s1_ms_r    <= in_elapsed_ms;
    end
  end

  // ---------------------------------------------------------------
  // Integrator state
  // ---------------------------------------------------------------
  oti_pkg::total_t odo_total_r,  odo_total_nxt;
  oti_pkg::total_t trip_total_r, trip_total_nxt;
  oti_pkg::rem_t   odo_rem_r,    odo_rem_nxt;
  oti_pkg::rem_t   trip_rem_r,   trip_rem_nxt;
  oti_pkg::ckpt_t  ckpt_r,       ckpt_nxt;
  logic            moving_r,     moving_nxt;

  // Clamp speed (over-limit reads as stopped) and interval, then one product
  oti_pkg::narrow_t speed_c;
  oti_pkg::narrow_t ms_c;
  oti_pkg::prod_t   prod;

  assign speed_c = (s1_speed_r > oti_pkg::SPEED_LIMIT_KPH) ? '0 : s1_speed_r[9:0];
  assign ms_c    = (s1_ms_r > oti_pkg::INTERVAL_LIMIT_MS) ? 10'(oti_pkg::INTERVAL_LIMIT_MS)
                                                            : s1_ms_r[9:0];
  assign prod    = {10'd0, speed_c} * {10'd0, ms_c};

  // Each meter keeps its own remainder
  oti_pkg::meter_res_t odo_step;
  oti_pkg::meter_res_t trip_step;

  oti_meter_step u_odo_step (
    .rem_i  (odo_rem_r),
    .prod_i (prod),
    .res_o  (odo_step)
  );

  oti_meter_step u_trip_step (
    .rem_i  (trip_rem_r),
    .prod_i (prod),
    .res_o  (trip_step)
  );

  // Result register payload
  oti_pkg::total_t out_odo_r,  out_odo_nxt;
  oti_pkg::total_t out_trip_r, out_trip_nxt;
  logic            out_save_r, out_save_nxt;

  logic [4:0] ckpt_sum;
  logic       save;
  logic       moving_now;

  always_comb begin
    odo_total_nxt  = odo_total_r;
    trip_total_nxt = trip_total_r;
    odo_rem_nxt    = odo_rem_r;
    trip_rem_nxt   = trip_rem_r;
    ckpt_nxt       = ckpt_r;
    moving_nxt     = moving_r;
    save           = 1'b0;
    ckpt_sum       = {1'b0, ckpt_r} + {3'd0, odo_step.inc};
    moving_now     = (speed_c != '0);

    case (oti_pkg::req_t'(s1_req_r))
      oti_pkg::REQ_ACCUM: begin
        odo_rem_nxt    = odo_step.rem;
        trip_rem_nxt   = trip_step.rem;
        odo_total_nxt  = oti_pkg::sat_add(odo_total_r, odo_step.inc);
        trip_total_nxt = oti_pkg::sat_add(trip_total_r, trip_step.inc);
        // checkpoint: save every CHECKPOINT_TENTHS tenths of odometer distance
        if (odo_step.inc != 2'd0) begin
          if (ckpt_sum >= oti_pkg::CKPT_LIMIT) begin
            save = 1'b1;
          end
          ckpt_nxt = 4'(oti_pkg::ckpt_wrap(ckpt_sum));
        end
        // vehicle just stopped with distance pending
        if (moving_r && !moving_now && (ckpt_nxt != '0)) begin
          save     = 1'b1;
          ckpt_nxt = '0;
        end
        moving_nxt = moving_now;
      end
      oti_pkg::REQ_TRIP_RESET: begin
        trip_total_nxt = '0;
        trip_rem_nxt   = '0;
        save           = 1'b1;
      end
      oti_pkg::REQ_INIT: begin
        // all-ones in storage means never written: start from zero and save
        odo_total_nxt  = cfg.odometer_stored;
        trip_total_nxt = cfg.trip_stored;
        if (cfg.odometer_stored == '1) begin
          odo_total_nxt = '0;
          save          = 1'b1;
        end
        if (cfg.trip_stored == '1) begin
          trip_total_nxt = '0;
          save           = 1'b1;
        end
        odo_rem_nxt  = '0;
        trip_rem_nxt = '0;
        ckpt_nxt     = '0;
        moving_nxt   = 1'b0;
      end
      default: begin
        // unused code: report current totals, no change
      end
    endcase

    out_odo_nxt  = odo_total_nxt;
    out_trip_nxt = trip_total_nxt;
    out_save_nxt = save;
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      odo_total_r  <= '0;
      trip_total_r <= '0;
      odo_rem_r    <= '0;
      trip_rem_r   <= '0;
      ckpt_r       <= '0;
      moving_r     <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_fire) begin
        odo_total_r  <= odo_total_nxt;
        trip_total_r <= trip_total_nxt;
        odo_rem_r    <= odo_rem_nxt;
        trip_rem_r   <= trip_rem_nxt;
        ckpt_r       <= ckpt_nxt;
        moving_r     <= moving_nxt;
      end
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_odo_r  <= out_odo_nxt;
      out_trip_r <= out_trip_nxt;
      out_save_r <= out_save_nxt;
    end
  end

  assign out_odometer_deci_km = out_odo_r;
  assign out_trip_deci_km     = out_trip_r;
  assign out_save_request     = out_save_r;

`ifndef ASSERT_OFF
  a_ckpt_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, ckpt_r} < oti_pkg::CKPT_LIMIT)
    else $error("checkpoint count out of range");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({2'b00, odo_rem_r} < oti_pkg::DECI_KM_UNITS) &&
    ({2'b00, trip_rem_r} < oti_pkg::DECI_KM_UNITS))
    else $error("remainder out of range");

  a_trip_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && (s1_req_r == oti_pkg::REQ_TRIP_RESET)) |=>
      (out_valid_r && (out_trip_r == '0) && out_save_r))
    else $error("trip reset beat did not clear trip and request save");

  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with free pipeline slot");

  a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && (s1_req_r == oti_pkg::REQ_ACCUM) && moving_r && (speed_c == '0))
      |=> (ckpt_r == '0))
    else $error("checkpoint count not cleared on stop");
`endif

endmodule
